### sv/tpda_pkg.sv
// ----------------------------------------------------------------------------
// tpda_pkg
// Shared types, constants and the weight code decoder for the ternary packed
// dot accumulate unit.
// ----------------------------------------------------------------------------
package tpda_pkg;

  localparam int MAX_LANES   = 4;
  localparam int NUM_ACT     = 5;
  localparam int ACT_W       = 8;
  localparam int SUM_W       = 32;
  // Five terms of at most 128 in magnitude fit in eleven signed bits.
  localparam int DOT_W       = 11;
  localparam int CODE_LIMIT  = 121;
  localparam int QUEUE_DEPTH = 2;
  localparam int RES_DEPTH   = 2;

  // Place value of each trit, most significant first.
  localparam int unsigned PLACE [NUM_ACT] = '{81, 27, 9, 3, 1};

  typedef logic signed [ACT_W-1:0] act_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic pos;
    logic neg;
  } trit_t;

  typedef struct packed {
    trit_t [NUM_ACT-1:0] trit;
    logic                bad;
  } lane_code_t;

  typedef struct packed {
    act_t       [NUM_ACT-1:0]   act;
    lane_code_t [MAX_LANES-1:0] lane;
    logic                       last;
  } item_t;

  typedef struct packed {
    sum_t [MAX_LANES-1:0] sum;
    logic                 bad;
  } res_t;

  // Splits a code into balanced trits. A code out of range gives all-zero
  // trits, so it adds nothing, and raises the bad flag. Each base-3 digit is
  // found by comparing the remainder with one and two times its place value
  // and taking off what the digit accounts for.
  function automatic lane_code_t decode_code(input act_t code);
    lane_code_t r;
    logic [7:0] u;
    logic [1:0] d;
    r = '0;
    u = '0;
    d = '0;
    if (int'(code) < -CODE_LIMIT || int'(code) > CODE_LIMIT) begin
      r.bad = 1'b1;
    end else begin
      u = 8'(int'(code) + CODE_LIMIT);
      for (int i = 0; i < NUM_ACT; i++) begin
        if (u >= 8'(2 * PLACE[i])) begin
          d = 2'd2;
          u = u - 8'(2 * PLACE[i]);
        end else if (u >= 8'(PLACE[i])) begin
          d = 2'd1;
          u = u - 8'(PLACE[i]);
        end else begin
          d = 2'd0;
        end
        r.trit[i].pos = (d == 2'd2);
        r.trit[i].neg = (d == 2'd0);
      end
    end
    return r;
  endfunction

endpackage

### sv/tpda_front.sv
// ----------------------------------------------------------------------------
// tpda_front
// Classifies an incoming beat: decodes each packed weight code into trits and
// flags codes that are out of range.
// ----------------------------------------------------------------------------
module tpda_front (
  input  tpda_pkg::act_t  act0,
  input  tpda_pkg::act_t  act1,
  input  tpda_pkg::act_t  act2,
  input  tpda_pkg::act_t  act3,
  input  tpda_pkg::act_t  act4,
  input  tpda_pkg::act_t  weight_code0,
  input  tpda_pkg::act_t  weight_code1,
  input  tpda_pkg::act_t  weight_code2,
  input  tpda_pkg::act_t  weight_code3,
  input  logic            last_group,
  output tpda_pkg::item_t item
);

  always_comb begin
    item.act[0]  = act0;
    item.act[1]  = act1;
    item.act[2]  = act2;
    item.act[3]  = act3;
    item.act[4]  = act4;
    item.lane[0] = tpda_pkg::decode_code(weight_code0);
    item.lane[1] = tpda_pkg::decode_code(weight_code1);
    item.lane[2] = tpda_pkg::decode_code(weight_code2);
    item.lane[3] = tpda_pkg::decode_code(weight_code3);
    item.last    = last_group;
  end

endmodule

### sv/tpda_queue.sv
// ----------------------------------------------------------------------------
// tpda_queue
// Short queue of decoded beats between the front and the accumulating back.
// ----------------------------------------------------------------------------
module tpda_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  tpda_pkg::item_t wr_item,
  output logic            full,
  input  logic            rd_en,
  output tpda_pkg::item_t rd_item,
  output logic            valid
);

  localparam int PTR_W = $clog2(tpda_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tpda_pkg::QUEUE_DEPTH + 1);

  tpda_pkg::item_t  mem [tpda_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(tpda_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(tpda_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(tpda_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

endmodule

### sv/tpda_back.sv
// ----------------------------------------------------------------------------
// tpda_back
// Forms the five-term ternary dot product of each lane, adds it to the lane
// sums and, on the last group, moves the sums into a small result buffer.
// ----------------------------------------------------------------------------
module tpda_back #(
  parameter int LANES = tpda_pkg::MAX_LANES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tpda_pkg::item_t in_item,
  output logic            in_take,
  input  logic            pop,
  output logic            empty,
  output tpda_pkg::res_t  res
);

  localparam int PTR_W = $clog2(tpda_pkg::RES_DEPTH);
  localparam int CNT_W = $clog2(tpda_pkg::RES_DEPTH + 1);

  logic signed [tpda_pkg::DOT_W-1:0] dot [tpda_pkg::MAX_LANES];
  tpda_pkg::sum_t acc      [tpda_pkg::MAX_LANES];
  tpda_pkg::sum_t acc_next [tpda_pkg::MAX_LANES];
  logic           err;
  logic           err_next;

  tpda_pkg::res_t   res_mem [tpda_pkg::RES_DEPTH];
  tpda_pkg::res_t   res_new;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             res_wr;
  logic             res_rd;

  // A non-final beat never needs buffer space, so only the last one waits.
  assign in_take = in_valid &&
                   (!in_item.last || count != CNT_W'(tpda_pkg::RES_DEPTH));
  assign res_wr  = in_take && in_item.last;
  assign empty   = (count == '0);
  assign res_rd  = pop && !empty;
  assign res     = res_mem[rd_ptr];

  always_comb begin
    err_next = err;
    for (int l = 0; l < tpda_pkg::MAX_LANES; l++) begin
      dot[l] = '0;
      for (int i = 0; i < tpda_pkg::NUM_ACT; i++) begin
        if (in_item.lane[l].trit[i].pos) begin
          dot[l] = dot[l] + tpda_pkg::DOT_W'(in_item.act[i]);
        end else if (in_item.lane[l].trit[i].neg) begin
          dot[l] = dot[l] - tpda_pkg::DOT_W'(in_item.act[i]);
        end
      end
      if (l < LANES) begin
        acc_next[l] = acc[l] + tpda_pkg::SUM_W'(dot[l]);
        err_next    = err_next | in_item.lane[l].bad;
      end else begin
        acc_next[l] = '0;
      end
    end
    for (int l = 0; l < tpda_pkg::MAX_LANES; l++) begin
      res_new.sum[l] = acc_next[l];
    end
    res_new.bad = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < tpda_pkg::MAX_LANES; l++) begin
        acc[l] <= '0;
      end
      err <= 1'b0;
    end else if (in_take) begin
      for (int l = 0; l < tpda_pkg::MAX_LANES; l++) begin
        acc[l] <= in_item.last ? '0 : acc_next[l];
      end
      err <= in_item.last ? 1'b0 : err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_mem[wr_ptr] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(tpda_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (res_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(tpda_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(res_wr) - CNT_W'(res_rd);
    end
  end

endmodule

### sv/ternary_packed_dot_accumulate_unit.sv
// ----------------------------------------------------------------------------
// ternary_packed_dot_accumulate_unit
// Accumulates five-trit packed ternary dot products into four 32-bit lane
// sums and delivers the sums and a sticky bad-code flag at each last group.
//
//   Channel  | Handshake          | Beat contents
//   ---------+--------------------+--------------------------------------------
//   input    | push / full        | act0..act4, weight_code0..3, last_group
//   result   | pop / empty        | sum0..sum3, bad_code
//
// One beat per cycle is sustained while no last-group beat waits for result
// buffer space; the lane adders in the back stage take one beat per cycle.
// A last group's result needs queue write, then accumulation into the buffer.
// Reset (synchronous) clears the lane sums, the error flag and both queues.
// A stalled result side holds back only last-group beats once its two-entry
// buffer is full; the two-entry input queue then fills and raises full.
// ----------------------------------------------------------------------------
module ternary_packed_dot_accumulate_unit #(
  parameter int LANES = tpda_pkg::MAX_LANES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic signed [7:0]           act0,
  input  logic signed [7:0]           act1,
  input  logic signed [7:0]           act2,
  input  logic signed [7:0]           act3,
  input  logic signed [7:0]           act4,
  input  logic signed [7:0]           weight_code0,
  input  logic signed [7:0]           weight_code1,
  input  logic signed [7:0]           weight_code2,
  input  logic signed [7:0]           weight_code3,
  input  logic                        last_group,
  input  logic                        pop,
  output logic                        empty,
  output logic signed [31:0]          sum0,
  output logic signed [31:0]          sum1,
  output logic signed [31:0]          sum2,
  output logic signed [31:0]          sum3,
  output logic                        bad_code
);

  tpda_pkg::item_t front_item;
  tpda_pkg::item_t queue_item;
  logic            queue_valid;
  logic            queue_take;
  tpda_pkg::res_t  res;

  tpda_front u_front (
    .act0         (act0),
    .act1         (act1),
    .act2         (act2),
    .act3         (act3),
    .act4         (act4),
    .weight_code0 (weight_code0),
    .weight_code1 (weight_code1),
    .weight_code2 (weight_code2),
    .weight_code3 (weight_code3),
    .last_group   (last_group),
    .item         (front_item)
  );

  tpda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (queue_take),
    .rd_item (queue_item),
    .valid   (queue_valid)
  );

  tpda_back #(
    .LANES (LANES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (queue_valid),
    .in_item  (queue_item),
    .in_take  (queue_take),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign sum0     = $signed(res.sum[0]);
  assign sum1     = $signed(res.sum[1]);
  assign sum2     = $signed(res.sum[2]);
  assign sum3     = $signed(res.sum[3]);
  assign bad_code = res.bad;

endmodule

### sv/tpda_checker.sv
// ----------------------------------------------------------------------------
// tpda_checker
// Port-level checks for the ternary packed dot accumulate unit.
// ----------------------------------------------------------------------------
module tpda_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input logic signed [31:0] sum0,
  input logic signed [31:0] sum1,
  input logic signed [31:0] sum2,
  input logic signed [31:0] sum3,
  input logic               bad_code
);

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not idle after reset");

  // With no beat pushed right after reset, no result appears.
  a_no_early_result: assert property (@(posedge clk)
    rst ##1 (!rst && !push) |=> empty)
    else $error("result appeared with no beat accepted");

  // The input queue fills only through an accepted push.
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full raised without a push");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sum0) && $stable(sum1) &&
                         $stable(sum2) && $stable(sum3) && $stable(bad_code)))
    else $error("waiting result changed");

endmodule

bind ternary_packed_dot_accumulate_unit tpda_checker u_tpda_checker (.*);

### tb/ternary_packed_dot_accumulate_unit_test.sv
// ----------------------------------------------------------------------------
// ternary_packed_dot_accumulate_unit_test
// Self-checking testbench. A scoreboard keeps its own copy of the four lane
// sums and the sticky code error. It decodes every accepted beat's weight
// codes by repeated division by three and queues the sums due at each last
// group. Directed beats cover the activation and code extremes, invalid codes
// and clearing between runs. Random runs of mostly valid codes follow, with
// bursts of idling on both sides.
// ----------------------------------------------------------------------------

typedef struct packed {
  tpda_pkg::act_t [tpda_pkg::NUM_ACT-1:0]   act;
  tpda_pkg::act_t [tpda_pkg::MAX_LANES-1:0] code;
  logic                                     last;
} group_t;

class lane_sum_board;
  localparam int LANES = tpda_pkg::MAX_LANES;

  tpda_pkg::sum_t  lane_total [LANES];
  logic            code_fault;
  tpda_pkg::res_t  pending_sums [$];
  int              mismatches;

  function new();
    foreach (lane_total[l]) lane_total[l] = '0;
    code_fault  = 1'b0;
    mismatches  = 0;
  endfunction

  // Digits come out least significant first, so they pair with act4 first.
  function int ternary_product(tpda_pkg::act_t code, tpda_pkg::act_t [4:0] act);
    int rest;
    int dot;
    rest = int'(code) + tpda_pkg::CODE_LIMIT;
    dot  = 0;
    for (int k = tpda_pkg::NUM_ACT - 1; k >= 0; k--) begin
      dot  += ((rest % 3) - 1) * int'(act[k]);
      rest  = rest / 3;
    end
    return dot;
  endfunction

  function void note_group(group_t g);
    tpda_pkg::res_t due;
    for (int l = 0; l < LANES; l++) begin
      if (int'(g.code[l]) < -tpda_pkg::CODE_LIMIT || int'(g.code[l]) > tpda_pkg::CODE_LIMIT)
        code_fault = 1'b1;
      else
        lane_total[l] = lane_total[l] + tpda_pkg::sum_t'(ternary_product(g.code[l], g.act));
    end
    if (g.last) begin
      for (int l = 0; l < LANES; l++) begin
        due.sum[l]    = lane_total[l];
        lane_total[l] = '0;
      end
      due.bad    = code_fault;
      code_fault = 1'b0;
      pending_sums.push_back(due);
    end
  endfunction

  task report(string what);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task check_sums(tpda_pkg::sum_t s0, tpda_pkg::sum_t s1, tpda_pkg::sum_t s2,
                  tpda_pkg::sum_t s3, logic bad);
    tpda_pkg::res_t want;
    tpda_pkg::sum_t seen [LANES];
    seen = '{s0, s1, s2, s3};
    if (pending_sums.size() == 0) begin
      report("result beat with no sums outstanding");
    end else begin
      want = pending_sums.pop_front();
      for (int l = 0; l < LANES; l++) begin
        if (seen[l] !== want.sum[l])
          report($sformatf("sum%0d got %0d, wanted %0d", l, $signed(seen[l]),
                           $signed(want.sum[l])));
      end
      if (bad !== want.bad)
        report($sformatf("bad_code got %b, wanted %b", bad, want.bad));
    end
  endtask
endclass

module ternary_packed_dot_accumulate_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CALM_TAIL    = 150;
  localparam int LIMIT_NS     = 10_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                push = 1'b0;
  logic                full;
  logic signed [7:0]   act0 = '0, act1 = '0, act2 = '0, act3 = '0, act4 = '0;
  logic signed [7:0]   weight_code0 = '0, weight_code1 = '0;
  logic signed [7:0]   weight_code2 = '0, weight_code3 = '0;
  logic                last_group = 1'b0;
  logic                pop = 1'b0;
  logic                empty;
  logic signed [31:0]  sum0, sum1, sum2, sum3;
  logic                bad_code;

  lane_sum_board sb = new();
  bit            steady = 1'b0;
  int            pop_hold = 0;

  ternary_packed_dot_accumulate_unit #(.LANES(tpda_pkg::MAX_LANES)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: check the beat taken at this edge, then choose next pop.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_sums(sum0, sum1, sum2, sum3, bad_code);
    if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      pop_hold = $urandom_range(1, 19) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic group_t make_group(int a0, int a1, int a2, int a3, int a4,
                                        int c0, int c1, int c2, int c3, bit last);
    group_t g;
    g.act  = {8'(a4), 8'(a3), 8'(a2), 8'(a1), 8'(a0)};
    g.code = {8'(c3), 8'(c2), 8'(c1), 8'(c0)};
    g.last = last;
    return g;
  endfunction

  function automatic tpda_pkg::act_t pick_act();
    if ($urandom_range(0, 7) == 0)
      return ($urandom_range(0, 1) == 1) ? 8'sd127 : -8'sd128;
    return tpda_pkg::act_t'($urandom_range(0, 255));
  endfunction

  // Out-of-range codes are 122..127 and -128..-122 as bytes.
  function automatic tpda_pkg::act_t pick_code();
    if ($urandom_range(0, 29) == 0) return tpda_pkg::act_t'($urandom_range(122, 134));
    return tpda_pkg::act_t'(int'($urandom_range(0, 242)) - tpda_pkg::CODE_LIMIT);
  endfunction

  function automatic group_t random_group(bit last);
    group_t g;
    for (int k = 0; k < tpda_pkg::NUM_ACT; k++) g.act[k] = pick_act();
    for (int l = 0; l < tpda_pkg::MAX_LANES; l++) g.code[l] = pick_code();
    g.last = last;
    return g;
  endfunction

  task push_group(group_t g);
    act0         <= g.act[0];
    act1         <= g.act[1];
    act2         <= g.act[2];
    act3         <= g.act[3];
    act4         <= g.act[4];
    weight_code0 <= g.code[0];
    weight_code1 <= g.code[1];
    weight_code2 <= g.code[2];
    weight_code3 <= g.code[3];
    last_group   <= g.last;
    push         <= 1'b1;
    do @(posedge clk); while (full);
    sb.note_group(g);
  endtask

  task hold_off(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain_sums();
    push <= 1'b0;
    do @(posedge clk); while (sb.pending_sums.size() != 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // All trits +1, then all -1, with the activation extremes.
    push_group(make_group(127, 127, 127, 127, 127, 121, 121, 121, 121, 1));
    push_group(make_group(-128, -128, -128, -128, -128, 121, 121, 121, 121, 1));
    push_group(make_group(-128, -128, -128, -128, -128, -121, -121, -121, -121, 1));
    // Code zero decodes to all-zero trits.
    push_group(make_group(127, 127, 127, 127, 127, -121, -121, -121, -121, 0));
    push_group(make_group(1, -1, 0, 5, -5, 0, 0, 0, 0, 1));
    // Invalid codes add nothing and flag the run; the flag clears afterwards.
    push_group(make_group(10, 20, 30, 40, 50, -122, 122, -128, 127, 0));
    push_group(make_group(3, 3, 3, 3, 3, 1, 2, 3, 4, 1));
    push_group(make_group(-1, -1, -1, -1, -1, 121, -121, 81, -81, 1));
    push_group(make_group(127, -128, 0, 1, -1, -128, 121, -121, 1, 1));
    push_group(make_group(0, 0, 0, 0, 0, 13, -13, 40, -40, 0));
    push_group(make_group(127, 127, -128, -128, 127, 121, 121, 121, 121, 1));
    // Sticky flag: a bad code early in a run, valid codes on its last group.
    push_group(make_group(5, 6, 7, 8, 9, 0, 0, 125, 0, 0));
    push_group(make_group(-7, 9, -11, 13, -15, 27, -27, 9, -9, 0));
    push_group(make_group(100, -100, 50, -50, 25, 3, -3, 1, -1, 1));
    for (int k = 0; k < 6; k++) push_group(random_group(k == 5));
    drain_sums();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_TAIL) steady = 1'b1;
      if (n == RANDOM_ITEMS / 2) drain_sums();
      else if (!steady && (n % 200) < 140 && $urandom_range(0, 4) == 0)
        hold_off($urandom_range(1, 19));
      push_group(random_group($urandom_range(0, 7) == 0 || n == RANDOM_ITEMS - 1));
    end

    drain_sums();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
